// ===== src/acs_pkg.sv =====
`default_nettype none

package acs_pkg;

  // Fixed field widths of the item and result words.
  localparam int unsigned OP_W    = 4;
  localparam int unsigned PC_W    = 10;
  localparam int unsigned BASE_W  = 10;
  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned FIELD_W = 32;

  // Item function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Instruction opcodes in encoding order; codes 14 and 15 act as no-ops.
  typedef enum logic [OP_W-1:0] {
    OP_HALT,
    OP_LDC,
    OP_MBR2AC,
    OP_MAR2AC,
    OP_AC2MBR,
    OP_AC2MAR,
    OP_READ,
    OP_WRITE,
    OP_ADD,
    OP_MUL,
    OP_AND,
    OP_OR,
    OP_IFGO,
    OP_NOP
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LADDR,
    ST_FADDR,
    ST_FETCH,
    ST_DADDR,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                      func;
    logic [ADDR_W-1:0]         load_address;
    logic [OP_W-1:0]           load_opcode;
    logic signed [FIELD_W-1:0] load_value;
  } in_word_t;

  typedef struct packed {
    logic                      still_running;
    logic [PC_W-1:0]           program_counter;
    logic signed [FIELD_W-1:0] accumulator;
    logic signed [FIELD_W-1:0] buffer_value;
    logic signed [FIELD_W-1:0] address_value;
  } out_word_t;

endpackage

`default_nettype wire

// ===== src/acs_ram.sv =====
`default_nettype none

module acs_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port; the read data register holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/acs_addr_mod.sv =====
`default_nettype none

module acs_addr_mod #(
  parameter int unsigned IN_W  = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [IN_W-1:0]          value_i,
  output logic                          done_o,
  output logic      [$clog2(DEPTH)-1:0] result_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NB    = (IN_W + 7) / 8;
  localparam int unsigned PAD_W = NB * 8;
  localparam int unsigned CNT_W = $clog2(NB + 1);
  localparam bit          POW2  = (DEPTH == (1 << AW));

  if (POW2) begin : g_mask
    // A power-of-two depth reduces to the low address bits at once.
    assign done_o   = start_i;
    assign result_o = AW'(value_i);
  end else begin : g_serial
    logic [PAD_W-1:0] sh_q;
    logic [AW-1:0]    rem_q, rem_d;
    logic [CNT_W-1:0] cnt_q;
    logic             busy_q;
    logic [AW-1:0]    fold_tab [256];
    logic [AW+7:0]    joined;
    logic [7:0]       fold_hi;
    logic [AW+1:0]    fold_sum;

    // Constant table: the weight of each byte that spills past the remainder width.
    for (genvar h = 0; h < 256; h++) begin : g_tab
      assign fold_tab[h] = AW'((64'(h) << AW) % 64'(DEPTH));
    end

    // One byte enters per cycle, most significant first. The spilled byte folds
    // back through the table and at most two subtractions of DEPTH finish the step.
    always_comb begin
      joined   = {rem_q, sh_q[PAD_W-1 -: 8]};
      fold_hi  = joined[AW+7 -: 8];
      fold_sum = (AW+2)'(fold_tab[fold_hi]) + (AW+2)'(joined[AW-1:0]);
      if (fold_sum >= (AW+2)'(2 * DEPTH)) begin
        rem_d = AW'(fold_sum - (AW+2)'(2 * DEPTH));
      end else if (fold_sum >= (AW+2)'(DEPTH)) begin
        rem_d = AW'(fold_sum - (AW+2)'(DEPTH));
      end else begin
        rem_d = AW'(fold_sum);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NB);
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end else begin
          busy_q <= 1'b0;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sh_q  <= PAD_W'(value_i);
        rem_q <= '0;
      end else if (busy_q && cnt_q != '0) begin
        sh_q  <= sh_q << 8;
        rem_q <= rem_d;
      end
    end

    assign done_o   = busy_q && (cnt_q == '0);
    assign result_o = rem_q;
  end

endmodule

`default_nettype wire

// ===== src/accumulator_cpu_step_top.sv =====
// Channel  Direction  Handshake                Word
// input    in         in_valid_i / in_ready_o  in_word_i  (acs_pkg::in_word_t)
// output   out        out_valid_o / out_ready_i out_word_o (acs_pkg::out_word_t)
// config   in         cfg_we_i, no wait        cfg_wdata_i (base address)
//
// One word is worked on at a time through the single port of the word memory.
// A load reduces its address and writes the word. A step reduces base plus PC, reads the
// instruction word, then for a read or write reduces MAR as the data address, or for a
// multiply sums 32-bit partial products. A step after halt goes straight to the result.
// Reset clears the machine registers; the word memory is not cleared.
// A stalled result holds the next word in its last state until taken.
`default_nettype none

module accumulator_cpu_step_top #(
  parameter int unsigned MEM_DEPTH  = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire acs_pkg::in_word_t            in_word_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output acs_pkg::out_word_t                out_word_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [acs_pkg::BASE_W-1:0]   cfg_wdata_i
);

  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned DW        = DATA_WIDTH;
  localparam int unsigned WORD_W    = acs_pkg::OP_W + DW;
  localparam int unsigned IN_W      = (DW > acs_pkg::BASE_W + 1) ? DW : acs_pkg::BASE_W + 1;
  localparam int unsigned MUL_STEPS = (DW > 32) ? 3 : 1;

  acs_pkg::state_e state_q, state_d;

  logic [acs_pkg::BASE_W-1:0] base_q;
  logic [acs_pkg::PC_W-1:0]   pc_q, pc_n, pc_inc;
  logic [DW-1:0]              acc_q, acc_n;
  logic [DW-1:0]              mbr_q, mbr_n;
  logic [DW-1:0]              mar_q, mar_n;
  logic                       run_q, run_n;

  logic                       exec_q;
  acs_pkg::op_e               op_q;
  logic [acs_pkg::OP_W-1:0]   load_op_q;
  logic [DW-1:0]              load_arg_q;
  logic [IN_W-1:0]            mod_val_q;
  logic                       mod_start_q, mod_start_d;
  logic [DW-1:0]              prod_q, prod_d;
  logic [1:0]                 mul_cnt_q;

  logic                       out_valid_q;
  acs_pkg::out_word_t         out_word_q;

  logic                       in_fire, out_free, out_load;
  logic                       mod_done;
  logic [AW-1:0]              mod_result;
  logic                       ram_we, ram_re;
  logic [WORD_W-1:0]          ram_wdata, ram_rdata;
  acs_pkg::op_e               fetch_op;
  logic [DW-1:0]              word_arg;
  logic                       fetch_rw;

  logic [63:0]                a_wide, b_wide, pp, pp_add;
  logic [31:0]                a_sel, b_sel;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign fetch_op = acs_pkg::op_e'(ram_rdata[WORD_W-1 -: acs_pkg::OP_W]);
  assign word_arg = ram_rdata[DW-1:0];
  assign fetch_rw = (fetch_op == acs_pkg::OP_READ) || (fetch_op == acs_pkg::OP_WRITE);

  // Word memory and the address reduction unit.
  acs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (mod_result),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  acs_addr_mod #(
    .IN_W  (IN_W),
    .DEPTH (MEM_DEPTH)
  ) u_addr_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mod_start_q),
    .value_i  (mod_val_q),
    .done_o   (mod_done),
    .result_o (mod_result)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acs_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_word_i.func == acs_pkg::FUNC_LOAD) begin
            state_d = acs_pkg::ST_LADDR;
          end else if (run_q) begin
            state_d = acs_pkg::ST_FADDR;
          end else begin
            state_d = acs_pkg::ST_DONE;
          end
        end
      end
      acs_pkg::ST_LADDR: begin
        if (mod_done) begin
          state_d = acs_pkg::ST_DONE;
        end
      end
      acs_pkg::ST_FADDR: begin
        if (mod_done) begin
          state_d = acs_pkg::ST_FETCH;
        end
      end
      acs_pkg::ST_FETCH: begin
        if (fetch_rw) begin
          state_d = acs_pkg::ST_DADDR;
        end else if (fetch_op == acs_pkg::OP_MUL) begin
          state_d = acs_pkg::ST_MUL;
        end else begin
          state_d = acs_pkg::ST_DONE;
        end
      end
      acs_pkg::ST_DADDR: begin
        if (mod_done) begin
          state_d = acs_pkg::ST_DONE;
        end
      end
      acs_pkg::ST_MUL: begin
        if (mul_cnt_q == 2'(MUL_STEPS - 1)) begin
          state_d = acs_pkg::ST_DONE;
        end
      end
      acs_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = acs_pkg::ST_IDLE;
        end
      end
      default: state_d = acs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, memory port and reduction start.
  always_comb begin
    in_ready_o  = (state_q == acs_pkg::ST_IDLE);
    out_load    = (state_q == acs_pkg::ST_DONE) && out_free;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = {acs_pkg::OP_HALT, mbr_q};
    mod_start_d = 1'b0;
    unique case (state_q)
      acs_pkg::ST_IDLE: begin
        mod_start_d = in_fire &&
                      ((in_word_i.func == acs_pkg::FUNC_LOAD) || run_q);
      end
      acs_pkg::ST_LADDR: begin
        ram_we    = mod_done;
        ram_wdata = {load_op_q, load_arg_q};
      end
      acs_pkg::ST_FADDR: begin
        ram_re = mod_done;
      end
      acs_pkg::ST_FETCH: begin
        mod_start_d = fetch_rw;
      end
      acs_pkg::ST_DADDR: begin
        ram_we = mod_done && (op_q == acs_pkg::OP_WRITE);
        ram_re = mod_done && (op_q == acs_pkg::OP_READ);
      end
      default: begin
      end
    endcase
  end

  // Multiply over 32-bit partial products, low DATA_WIDTH bits kept.
  always_comb begin
    a_wide = 64'(acc_q);
    b_wide = 64'(mbr_q);
    unique case (mul_cnt_q)
      2'd1:    begin a_sel = a_wide[31:0];  b_sel = b_wide[63:32]; end
      2'd2:    begin a_sel = a_wide[63:32]; b_sel = b_wide[31:0];  end
      default: begin a_sel = a_wide[31:0];  b_sel = b_wide[31:0];  end
    endcase
    pp     = 64'(a_sel) * 64'(b_sel);
    pp_add = (mul_cnt_q == 2'd0) ? pp : (pp << 32);
    prod_d = ((mul_cnt_q == 2'd0) ? '0 : prod_q) + DW'(pp_add);
  end

  // Machine state after the current word.
  always_comb begin
    pc_inc = pc_q + 1'b1;
    pc_n   = pc_q;
    acc_n  = acc_q;
    mbr_n  = mbr_q;
    mar_n  = mar_q;
    run_n  = run_q;
    if (exec_q) begin
      pc_n = pc_inc;
      unique case (op_q)
        acs_pkg::OP_HALT: begin
          run_n = 1'b0;
          pc_n  = pc_q;
        end
        acs_pkg::OP_LDC:    acc_n = word_arg;
        acs_pkg::OP_MBR2AC: acc_n = mbr_q;
        acs_pkg::OP_MAR2AC: acc_n = mar_q;
        acs_pkg::OP_AC2MBR: mbr_n = acc_q;
        acs_pkg::OP_AC2MAR: mar_n = acc_q;
        acs_pkg::OP_READ:   mbr_n = word_arg;
        acs_pkg::OP_ADD:    acc_n = acc_q + mbr_q;
        acs_pkg::OP_MUL:    acc_n = prod_q;
        acs_pkg::OP_AND:    acc_n = DW'((acc_q != '0) && (mbr_q != '0));
        acs_pkg::OP_OR:     acc_n = DW'((acc_q != '0) || (mbr_q != '0));
        acs_pkg::OP_IFGO: begin
          if (acc_q != '0) begin
            pc_n = acs_pkg::PC_W'(word_arg);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acs_pkg::ST_IDLE;
      base_q      <= '0;
      pc_q        <= '0;
      acc_q       <= '0;
      mbr_q       <= '0;
      mar_q       <= '0;
      run_q       <= 1'b1;
      mod_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mod_start_q <= mod_start_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (out_load) begin
        pc_q        <= pc_n;
        acc_q       <= acc_n;
        mbr_q       <= mbr_n;
        mar_q       <= mar_n;
        run_q       <= run_n;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, operand and result registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      exec_q     <= (in_word_i.func == acs_pkg::FUNC_STEP) && run_q;
      load_op_q  <= in_word_i.load_opcode;
      load_arg_q <= DW'($unsigned(in_word_i.load_value));
      if (in_word_i.func == acs_pkg::FUNC_LOAD) begin
        mod_val_q <= IN_W'(in_word_i.load_address);
      end else begin
        mod_val_q <= IN_W'({1'b0, base_q} + {1'b0, pc_q});
      end
    end
    if (state_q == acs_pkg::ST_FETCH) begin
      op_q      <= fetch_op;
      mod_val_q <= IN_W'(mar_q);
      mul_cnt_q <= 2'd0;
    end
    if (state_q == acs_pkg::ST_MUL) begin
      prod_q    <= prod_d;
      mul_cnt_q <= mul_cnt_q + 1'b1;
    end
    if (out_load) begin
      out_word_q.still_running   <= run_n;
      out_word_q.program_counter <= pc_n;
      out_word_q.accumulator     <= acs_pkg::FIELD_W'(acc_n);
      out_word_q.buffer_value    <= acs_pkg::FIELD_W'(mbr_n);
      out_word_q.address_value   <= acs_pkg::FIELD_W'(mar_n);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // A word is taken only when the previous one has left the sequencer.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input accepted while a word is in progress");

  // Once halted, only reset restarts the machine.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |=> !run_q)
    else $error("run flag rose without reset");

  // Memory writes come only from a load or a write instruction.
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == acs_pkg::ST_LADDR) ||
               ((state_q == acs_pkg::ST_DADDR) && (op_q == acs_pkg::OP_WRITE)))
    else $error("memory write outside a load or write instruction");

  // The machine registers change only when a result is produced.
  a_commit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(pc_q) && $stable(acc_q) && $stable(run_q))
    else $error("machine state changed without a result");

endmodule

`default_nettype wire
